// ----- src/twfe_pkg.sv -----
// Shared constants and types for the tick window feature extractor.
// No dependencies; the divider, the extractor and both bench files import this package.
`default_nettype none
package twfe_pkg;
    localparam int PRICE_BITS  = 32;
    localparam int VOLUME_BITS = 32;
    localparam int DEPTH       = 10;
    localparam int IDX_BITS    = $clog2(DEPTH);
    localparam int FRAC        = 24;
    localparam int Q_BITS      = 32;
    localparam int SUM_BITS    = PRICE_BITS + 1;
    localparam int VSUM_BITS   = VOLUME_BITS + $clog2(DEPTH);
    localparam int FLOW_BITS   = VSUM_BITS + 1;
    localparam int PROD_BITS   = SUM_BITS + VOLUME_BITS;
    localparam int DIV_BITS    = SUM_BITS + VSUM_BITS;

    localparam logic [1:0] SIDE_BUY  = 2'b01;
    localparam logic [1:0] SIDE_SELL = 2'b11;

    typedef struct packed {
        logic                start;
        logic                neg;
        logic [DIV_BITS-1:0] mag;
        logic [DIV_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [Q_BITS-1:0] quot;
    } div_rsp_t;
endpackage
`default_nettype wire

// ----- src/twfe_if.sv -----
// Valid/ready channel interfaces for ticks in and feature vectors out.
// Depends on nothing.
`default_nettype none
interface tick_if;
    logic               valid;
    logic               ready;
    logic [31:0]        bid_price;
    logic [31:0]        ask_price;
    logic [31:0]        bid_volume;
    logic [31:0]        ask_volume;
    logic [31:0]        trade_volume;
    logic signed [1:0]  trade_side;
    modport source (output valid, bid_price, ask_price, bid_volume, ask_volume,
                     trade_volume, trade_side, input ready);
    modport sink (input valid, bid_price, ask_price, bid_volume, ask_volume,
                   trade_volume, trade_side, output ready);
endinterface

interface feat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] return_1;
    logic signed [31:0] return_5;
    logic signed [32:0] spread;
    logic signed [31:0] norm_spread;
    logic signed [25:0] book_imbalance;
    logic signed [36:0] trade_flow;
    logic [30:0]        volume_ratio;
    logic signed [31:0] momentum_9;
    logic signed [31:0] vwap_deviation;
    modport source (output valid, return_1, return_5, spread, norm_spread, book_imbalance,
                     trade_flow, volume_ratio, momentum_9, vwap_deviation, input ready);
    modport sink (input valid, return_1, return_5, spread, norm_spread, book_imbalance,
                   trade_flow, volume_ratio, momentum_9, vwap_deviation, output ready);
endinterface
`default_nettype wire

// ----- src/twfe_div.sv -----
// Shared radix-2 restoring divider: sign-magnitude numerator shifted by FRAC,
// one quotient bit per cycle, saturated to signed Q8.24. Uses twfe_pkg.
`default_nettype none
module twfe_div
    import twfe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  div_req_t  req,
    output div_rsp_t  rsp
);
    localparam int NUM_BITS = DIV_BITS + FRAC;
    localparam int CNT_BITS = $clog2(Q_BITS);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

    state_t              state_reg, state_next;
    logic [DIV_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] den_reg, den_next;
    logic [Q_BITS-1:0]   low_reg, low_next;
    logic [Q_BITS-1:0]   q_reg, q_next;
    logic                neg_reg, neg_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    logic [NUM_BITS-1:0] num;
    logic [DIV_BITS-1:0] hi_ext;
    logic [DIV_BITS:0]   rem2;
    logic                ge;
    logic [Q_BITS-1:0]   cap;
    logic [Q_BITS-1:0]   qc;

    always_comb begin
        num    = {req.mag, FRAC'(0)};
        hi_ext = DIV_BITS'(num[NUM_BITS-1:Q_BITS]);
        rem2   = {rem_reg, low_reg[Q_BITS-1]};
        ge     = rem2 >= {1'b0, den_reg};
        cap    = neg_reg ? (Q_BITS'(1) << (Q_BITS - 1)) : ((Q_BITS'(1) << (Q_BITS - 1)) - 1'b1);
        qc     = (q_reg > cap) ? cap : q_reg;
    end

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    neg_next = req.neg;
                    den_next = req.den;
                    rem_next = hi_ext;
                    low_next = num[Q_BITS-1:0];
                    cnt_next = '0;
                    q_next   = '0;
                    if (req.den == '0) begin
                        neg_next   = 1'b0;
                        state_next = S_FIN;
                    end else if (hi_ext >= req.den) begin
                        // quotient cannot fit: force saturation
                        q_next     = '1;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN: begin
                rem_next = ge ? DIV_BITS'(rem2 - {1'b0, den_reg}) : rem2[DIV_BITS-1:0];
                q_next   = {q_reg[Q_BITS-2:0], ge};
                low_next = {low_reg[Q_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(Q_BITS - 1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            rem_reg   <= '0;
            den_reg   <= '0;
            low_reg   <= '0;
            q_reg     <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            den_reg   <= den_next;
            low_reg   <= low_next;
            q_reg     <= q_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        rsp.busy = state_reg != S_IDLE;
        rsp.done = state_reg == S_FIN;
        rsp.quot = neg_reg ? (~qc + 1'b1) : qc;
    end
endmodule
`default_nettype wire

// ----- src/tick_window_feature_extractor.sv -----
// Tick window feature extractor. Warm-up ticks (first nine) are taken one per cycle.
// From the tenth tick on, each accepted tick runs a multiply-accumulate pass, seven
// divisions on the shared divider (cut short for a zero divisor or an overflowing
// quotient) and a load of the output register; no new tick is taken until that is done
// and the output register is free. Reset clears the fill count, sequencer and output
// valid.
`default_nettype none
module tick_window_feature_extractor
    import twfe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    tick_if.sink      tick,
    feat_if.source    feat
);
    typedef enum logic [2:0] {ST_IDLE, ST_MAC, ST_ISSUE, ST_WAIT, ST_OUT} state_t;
    typedef enum logic [2:0] {JOB_R1, JOB_R5, JOB_NS, JOB_BI, JOB_VR, JOB_M9, JOB_VW} job_t;

    localparam int MAC_CNT_BITS = $clog2(2 * DEPTH + 1);
    localparam int FILL_BITS    = $clog2(DEPTH + 1);

    // history shift line, newest at index 0
    logic [SUM_BITS-1:0]    hs_reg [DEPTH];
    logic [VOLUME_BITS-1:0] hv_reg [DEPTH];
    logic [1:0]             hd_reg [DEPTH];

    logic [PRICE_BITS-1:0]  bid_reg, ask_reg;
    logic [VOLUME_BITS-1:0] bv_reg, av_reg;

    state_t                 state_reg;
    job_t                   job_reg;
    logic [FILL_BITS-1:0]   fill_reg;
    logic [MAC_CNT_BITS-1:0] cnt_reg;
    logic                   acc_psum_reg;
    logic                   acc_valid_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [DIV_BITS-1:0]    psum_reg, cur_reg;
    logic [VSUM_BITS-1:0]   vsum_reg;
    logic signed [FLOW_BITS-1:0] flow_reg;

    logic signed [31:0] r1_reg, r5_reg, ns_reg, m9_reg, vw_reg;
    logic signed [25:0] bi_reg;
    logic [30:0]        vr_reg;

    logic               out_valid_reg;
    logic signed [31:0] o_r1_reg, o_r5_reg, o_ns_reg, o_m9_reg, o_vw_reg;
    logic signed [32:0] o_sp_reg;
    logic signed [25:0] o_bi_reg;
    logic signed [36:0] o_fl_reg;
    logic [30:0]        o_vr_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    logic                   accept;
    logic [IDX_BITS-1:0]    idx;
    logic [SUM_BITS-1:0]    mul_a;
    logic [VOLUME_BITS-1:0] mul_b;
    logic [SUM_BITS-1:0]    s0, s1, s5, s9;
    logic [PRICE_BITS-1:0]  sdif;

    twfe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign accept     = tick.valid && tick.ready;
    assign tick.ready = state_reg == ST_IDLE;

    always_comb begin
        s0   = hs_reg[0];
        s1   = hs_reg[1];
        s5   = hs_reg[5];
        s9   = hs_reg[DEPTH-1];
        idx  = (cnt_reg < MAC_CNT_BITS'(DEPTH)) ? cnt_reg[IDX_BITS-1:0]
             : (cnt_reg < MAC_CNT_BITS'(2 * DEPTH)) ? IDX_BITS'(cnt_reg - MAC_CNT_BITS'(DEPTH))
             : '0;
        mul_a = (cnt_reg < MAC_CNT_BITS'(DEPTH)) ? hs_reg[idx] : s0;
        mul_b = hv_reg[idx];
        sdif  = (ask_reg >= bid_reg) ? ask_reg - bid_reg : bid_reg - ask_reg;
    end

    // operands of the current division job
    always_comb begin
        dreq.start = state_reg == ST_ISSUE;
        dreq.neg   = 1'b0;
        dreq.mag   = '0;
        dreq.den   = '0;
        case (job_reg)
            JOB_R1: begin
                dreq.neg = s0 < s1;
                dreq.mag = DIV_BITS'((s0 < s1) ? s1 - s0 : s0 - s1);
                dreq.den = DIV_BITS'(s1);
            end
            JOB_R5: begin
                dreq.neg = s0 < s5;
                dreq.mag = DIV_BITS'((s0 < s5) ? s5 - s0 : s0 - s5);
                dreq.den = DIV_BITS'(s5);
            end
            JOB_NS: begin
                dreq.neg = ask_reg < bid_reg;
                dreq.mag = DIV_BITS'({sdif, 1'b0});
                dreq.den = DIV_BITS'(s0);
            end
            JOB_BI: begin
                dreq.neg = bv_reg < av_reg;
                dreq.mag = DIV_BITS'((bv_reg < av_reg) ? av_reg - bv_reg : bv_reg - av_reg);
                dreq.den = DIV_BITS'({1'b0, bv_reg} + {1'b0, av_reg});
            end
            JOB_VR: begin
                dreq.mag = DIV_BITS'(bv_reg);
                dreq.den = DIV_BITS'(av_reg);
            end
            JOB_M9: begin
                dreq.neg = s0 < s9;
                dreq.mag = DIV_BITS'((s0 < s9) ? s9 - s0 : s0 - s9);
                dreq.den = DIV_BITS'(s9);
            end
            JOB_VW: begin
                dreq.neg = cur_reg < psum_reg;
                dreq.mag = (cur_reg < psum_reg) ? psum_reg - cur_reg : cur_reg - psum_reg;
                dreq.den = psum_reg;
            end
            default: dreq.neg = 1'b0;
        endcase
    end

    // payload storage, no reset
    always_ff @(posedge clk) begin
        if (accept) begin
            for (int i = DEPTH - 1; i > 0; i--) begin
                hs_reg[i] <= hs_reg[i-1];
                hv_reg[i] <= hv_reg[i-1];
                hd_reg[i] <= hd_reg[i-1];
            end
            hs_reg[0] <= {1'b0, tick.bid_price} + {1'b0, tick.ask_price};
            hv_reg[0] <= tick.trade_volume;
            hd_reg[0] <= tick.trade_side;
            bid_reg   <= tick.bid_price;
            ask_reg   <= tick.ask_price;
            bv_reg    <= tick.bid_volume;
            av_reg    <= tick.ask_volume;
        end
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_R1;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            acc_psum_reg  <= 1'b0;
            acc_valid_reg <= 1'b0;
            psum_reg      <= '0;
            cur_reg       <= '0;
            vsum_reg      <= '0;
            flow_reg      <= '0;
            r1_reg        <= '0;
            r5_reg        <= '0;
            ns_reg        <= '0;
            bi_reg        <= '0;
            vr_reg        <= '0;
            m9_reg        <= '0;
            vw_reg        <= '0;
            out_valid_reg <= 1'b0;
            o_r1_reg      <= '0;
            o_r5_reg      <= '0;
            o_sp_reg      <= '0;
            o_ns_reg      <= '0;
            o_bi_reg      <= '0;
            o_fl_reg      <= '0;
            o_vr_reg      <= '0;
            o_m9_reg      <= '0;
            o_vw_reg      <= '0;
        end else begin
            if (out_valid_reg && feat.ready && state_reg != ST_OUT) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (fill_reg < FILL_BITS'(DEPTH)) begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        if (fill_reg >= FILL_BITS'(DEPTH - 1)) begin
                            state_reg     <= ST_MAC;
                            cnt_reg       <= '0;
                            acc_valid_reg <= 1'b0;
                            psum_reg      <= '0;
                            cur_reg       <= '0;
                            vsum_reg      <= '0;
                            flow_reg      <= '0;
                        end
                    end
                end
                ST_MAC: begin
                    // accumulate last cycle's product, launch the next one
                    if (acc_valid_reg) begin
                        if (acc_psum_reg) begin
                            psum_reg <= psum_reg + DIV_BITS'(prod_reg);
                        end else begin
                            cur_reg <= cur_reg + DIV_BITS'(prod_reg);
                        end
                    end
                    if (cnt_reg < MAC_CNT_BITS'(DEPTH)) begin
                        vsum_reg <= vsum_reg + VSUM_BITS'(mul_b);
                        if (hd_reg[idx] == SIDE_BUY) begin
                            flow_reg <= flow_reg + FLOW_BITS'(mul_b);
                        end else if (hd_reg[idx] == SIDE_SELL) begin
                            flow_reg <= flow_reg - FLOW_BITS'(mul_b);
                        end
                    end
                    acc_psum_reg  <= cnt_reg < MAC_CNT_BITS'(DEPTH);
                    acc_valid_reg <= cnt_reg < MAC_CNT_BITS'(2 * DEPTH);
                    cnt_reg       <= cnt_reg + 1'b1;
                    if (cnt_reg == MAC_CNT_BITS'(2 * DEPTH)) begin
                        state_reg <= ST_ISSUE;
                        job_reg   <= JOB_R1;
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (drsp.done) begin
                        state_reg <= ST_ISSUE;
                        case (job_reg)
                            JOB_R1: begin
                                r1_reg  <= drsp.quot;
                                job_reg <= JOB_R5;
                            end
                            JOB_R5: begin
                                r5_reg  <= drsp.quot;
                                job_reg <= JOB_NS;
                            end
                            JOB_NS: begin
                                ns_reg  <= drsp.quot;
                                job_reg <= JOB_BI;
                            end
                            JOB_BI: begin
                                bi_reg  <= drsp.quot[25:0];
                                job_reg <= JOB_VR;
                            end
                            JOB_VR: begin
                                vr_reg  <= (av_reg == '0) ? (31'(1) << FRAC) : drsp.quot[30:0];
                                job_reg <= JOB_M9;
                            end
                            JOB_M9: begin
                                m9_reg  <= drsp.quot;
                                job_reg <= JOB_VW;
                            end
                            JOB_VW: begin
                                vw_reg    <= (vsum_reg == '0) ? '0 : drsp.quot;
                                state_reg <= ST_OUT;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!out_valid_reg || feat.ready) begin
                        out_valid_reg <= 1'b1;
                        o_r1_reg      <= r1_reg;
                        o_r5_reg      <= r5_reg;
                        o_sp_reg      <= {1'b0, ask_reg} - {1'b0, bid_reg};
                        o_ns_reg      <= ns_reg;
                        o_bi_reg      <= bi_reg;
                        o_fl_reg      <= flow_reg;
                        o_vr_reg      <= vr_reg;
                        o_m9_reg      <= m9_reg;
                        o_vw_reg      <= vw_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign feat.valid          = out_valid_reg;
    assign feat.return_1       = o_r1_reg;
    assign feat.return_5       = o_r5_reg;
    assign feat.spread         = o_sp_reg;
    assign feat.norm_spread    = o_ns_reg;
    assign feat.book_imbalance = o_bi_reg;
    assign feat.trade_flow     = o_fl_reg;
    assign feat.volume_ratio   = o_vr_reg;
    assign feat.momentum_9     = o_m9_reg;
    assign feat.vwap_deviation = o_vw_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_BITS'(DEPTH))
        else $error("fill count past depth");

    a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        tick.ready |-> !drsp.busy)
        else $error("divider busy while taking a tick");

    a_issue_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> !drsp.busy)
        else $error("divider request while busy");

    a_result_after_divide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result shown without finishing the divide sequence");
endmodule
`default_nettype wire

// ----- bench/feature_checker.sv -----
// Checker for the tick window feature extractor: watches both channels,
// predicts every feature vector from the accepted ticks and compares.
// Depends on twfe_pkg and the tick_if / feat_if interfaces.
module feature_checker
    import twfe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    tick_if           tick,
    feat_if           feat,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic signed [31:0] return_1;
        logic signed [31:0] return_5;
        logic signed [32:0] spread;
        logic signed [31:0] norm_spread;
        logic signed [25:0] book_imbalance;
        logic signed [36:0] trade_flow;
        logic [30:0]        volume_ratio;
        logic signed [31:0] momentum_9;
        logic signed [31:0] vwap_deviation;
    } features_t;

    features_t        expected_features[$];
    logic [32:0]      sum_ring[DEPTH];
    logic [31:0]      vol_ring[DEPTH];
    int               side_ring[DEPTH];
    int               ticks_seen;
    int               slot;

    assign pending = expected_features.size();

    // Truncated Q8.24 quotient of a magnitude, signed, clamped to 32 bits.
    function automatic longint q824(bit neg, logic [127:0] mag, logic [127:0] den);
        logic [127:0] q;
        longint       cap;
        if (den == 0)
            return 0;
        q   = (mag << FRAC) / den;
        cap = neg ? 64'sh8000_0000 : 64'sh7FFF_FFFF;
        if (q > cap)
            q = cap;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint rel_change(logic [63:0] a, logic [63:0] b, logic [63:0] den);
        return (a < b) ? q824(1, b - a, den) : q824(0, a - b, den);
    endfunction

    task automatic absorb_tick();
        features_t    f;
        logic [63:0]  bid, ask, bv, av, s0, s1, s5, s9, vsum;
        logic [127:0] psum, cur;
        longint       flow;
        int           sd;
        bid = tick.bid_price;
        ask = tick.ask_price;
        bv  = tick.bid_volume;
        av  = tick.ask_volume;
        sd  = (tick.trade_side == SIDE_BUY) ? 1 : (tick.trade_side == SIDE_SELL) ? -1 : 0;
        sum_ring[slot]  = 33'(bid + ask);
        vol_ring[slot]  = tick.trade_volume;
        side_ring[slot] = sd;
        slot = (slot + 1) % DEPTH;
        if (ticks_seen < DEPTH)
            ticks_seen++;
        if (ticks_seen < DEPTH)
            return;
        s0 = sum_ring[(slot + DEPTH - 1) % DEPTH];
        s1 = sum_ring[(slot + DEPTH - 2) % DEPTH];
        s5 = sum_ring[(slot + DEPTH - 6) % DEPTH];
        s9 = sum_ring[slot];
        flow = 0;
        vsum = 0;
        psum = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            flow += side_ring[i] * longint'(vol_ring[i]);
            vsum += vol_ring[i];
            psum += 128'(sum_ring[i]) * 128'(vol_ring[i]);
        end
        f.return_1       = 32'(rel_change(s0, s1, s1));
        f.return_5       = 32'(rel_change(s0, s5, s5));
        f.spread         = 33'(ask) - 33'(bid);
        f.norm_spread    = (ask < bid) ? 32'(q824(1, 2 * (bid - ask), s0))
                                       : 32'(q824(0, 2 * (ask - bid), s0));
        f.book_imbalance = 26'(rel_change(bv, av, bv + av));
        f.trade_flow     = 37'(flow);
        f.volume_ratio   = (av == 0) ? 31'(1 << FRAC) : 31'(q824(0, bv, av));
        f.momentum_9     = 32'(rel_change(s0, s9, s9));
        cur = 128'(s0) * 128'(vsum);
        if (vsum == 0)
            f.vwap_deviation = 0;
        else if (cur >= psum)
            f.vwap_deviation = 32'(q824(0, cur - psum, psum));
        else
            f.vwap_deviation = 32'(q824(1, psum - cur, psum));
        expected_features.push_back(f);
    endtask

    task automatic compare_features();
        features_t e;
        if (expected_features.size() == 0)
        begin
            $error("feature vector with no tick behind it");
            fail_count++;
            return;
        end
        e = expected_features.pop_front();
        if (feat.return_1 !== e.return_1)
        begin $error("return_1 exp %0d got %0d", e.return_1, feat.return_1); fail_count++; end
        if (feat.return_5 !== e.return_5)
        begin $error("return_5 exp %0d got %0d", e.return_5, feat.return_5); fail_count++; end
        if (feat.spread !== e.spread)
        begin $error("spread exp %0d got %0d", e.spread, feat.spread); fail_count++; end
        if (feat.norm_spread !== e.norm_spread)
        begin
            $error("norm_spread exp %0d got %0d", e.norm_spread, feat.norm_spread);
            fail_count++;
        end
        if (feat.book_imbalance !== e.book_imbalance)
        begin
            $error("book_imbalance exp %0d got %0d", e.book_imbalance, feat.book_imbalance);
            fail_count++;
        end
        if (feat.trade_flow !== e.trade_flow)
        begin $error("trade_flow exp %0d got %0d", e.trade_flow, feat.trade_flow); fail_count++; end
        if (feat.volume_ratio !== e.volume_ratio)
        begin
            $error("volume_ratio exp %0d got %0d", e.volume_ratio, feat.volume_ratio);
            fail_count++;
        end
        if (feat.momentum_9 !== e.momentum_9)
        begin $error("momentum_9 exp %0d got %0d", e.momentum_9, feat.momentum_9); fail_count++; end
        if (feat.vwap_deviation !== e.vwap_deviation)
        begin
            $error("vwap_deviation exp %0d got %0d", e.vwap_deviation, feat.vwap_deviation);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_seen <= 0;
            slot       <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (feat.valid && feat.ready)
                compare_features();
            if (tick.valid && tick.ready)
                absorb_tick();
        end
    end

endmodule

// ----- bench/tb_tick_window_feature_extractor.sv -----
// Testbench top: clock, reset, tick stimulus with random gaps and output stalls.
// Depends on twfe_pkg, the channel interfaces, feature_checker and the block.
module tb_tick_window_feature_extractor;
    import twfe_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   long_hold;
    bit   stim_done;

    tick_if tick ();
    feat_if feat ();

    tick_window_feature_extractor u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .feat  (feat)
    );

    feature_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .feat       (feat),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [31:0] pick_word(int mode);
        case (mode)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 20);
            3: return $urandom_range(1000, 1100);
            default: return $urandom;
        endcase
    endfunction

    // Valid stays high after acceptance until the next gap or the next request.
    task automatic send_tick(logic [31:0] bid, logic [31:0] ask, logic [31:0] bv,
                             logic [31:0] av, logic [31:0] tv, logic [1:0] sd);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            tick.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick.valid        <= 1'b1;
        tick.bid_price    <= bid;
        tick.ask_price    <= ask;
        tick.bid_volume   <= bv;
        tick.ask_volume   <= av;
        tick.trade_volume <= tv;
        tick.trade_side   <= sd;
        @(posedge clk);
        while (!tick.ready)
            @(posedge clk);
    endtask

    // Mostly realistic books around a random price near 100000, some fully random words.
    task automatic send_random_tick();
        logic [31:0] base;
        logic [31:0] bid;
        base = $urandom_range(0, 3) == 0 ? pick_word($urandom_range(0, 4))
                                         : $urandom_range(90_000, 110_000);
        bid = base;
        send_tick(bid, $urandom_range(0, 5) == 0 ? pick_word($urandom_range(0, 4))
                                                 : bid + $urandom_range(0, 50),
                  pick_word($urandom_range(0, 4)), pick_word($urandom_range(0, 4)),
                  pick_word($urandom_range(0, 4)), 2'($urandom_range(0, 3)));
    endtask

    // Receiver: random stalls, plus one long hold-off while ticks keep coming.
    initial
    begin
        int stall;
        feat.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                feat.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                long_hold = 0;
            end
            stall = $urandom_range(0, 4);
            if ($urandom_range(0, 7) == 0)
                stall = 0;
            if (stall != 0)
            begin
                feat.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            feat.ready <= 1'b1;
            @(posedge clk);
            while (!feat.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        tick.valid        <= 1'b0;
        tick.bid_price    <= '0;
        tick.ask_price    <= '0;
        tick.bid_volume   <= '0;
        tick.ask_volume   <= '0;
        tick.trade_volume <= '0;
        tick.trade_side   <= '0;
        rst_n     = 1'b0;
        long_hold = 0;
        stim_done = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // warm-up ticks with zero volume, then the extremes and zero denominators
        for (int i = 0; i < 9; i++)
            send_tick(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'b00);
        send_tick(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'b10);
        send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, SIDE_BUY);
        send_tick(32'd1, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, SIDE_SELL);
        send_tick(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 2'b10);
        send_tick(32'd0, 32'hFFFF_FFFF, 32'd5, 32'd5, 32'd0, SIDE_BUY);
        send_tick(32'd100, 32'd101, 32'd3, 32'd7, 32'd10, SIDE_SELL);
        send_tick(32'd1, 32'd1, 32'd1, 32'd0, 32'hFFFF_FFFF, SIDE_BUY);
        send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 2'b00);

        for (int i = 0; i < 500; i++)
        begin
            if (i == 150)
                long_hold = 1;
            send_random_tick();
        end
        tick.valid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tick_window_feature_extractor regression: pass");
        else
            $display("tick_window_feature_extractor regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tick_window_feature_extractor regression: fail");
        $finish;
    end

endmodule

// ----- tick_window_feature_extractor.f -----
src/twfe_pkg.sv
src/twfe_if.sv
src/twfe_div.sv
src/tick_window_feature_extractor.sv
bench/feature_checker.sv
bench/tb_tick_window_feature_extractor.sv
